### rtl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants of the motor fault supervisor: register
// indexes, reset values, configuration and supervisor state records.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SPIN_SPEED_THRESHOLD = 4'd0,
        REG_SPIN_ANGLE_LIMIT     = 4'd1,
        REG_SPIN_TICK_LIMIT      = 4'd2,
        REG_TILT_LIMIT           = 4'd3,
        REG_LAND_ANGLE_WINDOW    = 4'd4,
        REG_LAND_INTERVAL        = 4'd5,
        REG_LAND_DELTA_LIMIT     = 4'd6,
        REG_LAND_STABLE_NEEDED   = 4'd7
    } cfg_idx_t;

    localparam logic [14:0] RST_SPIN_SPEED_THRESHOLD = 15'd30;
    localparam logic [14:0] RST_SPIN_ANGLE_LIMIT     = 15'd3000;
    localparam logic [15:0] RST_SPIN_TICK_LIMIT      = 16'd50;
    localparam logic [14:0] RST_TILT_LIMIT           = 15'd3000;
    localparam logic [14:0] RST_LAND_ANGLE_WINDOW    = 15'd500;
    localparam logic [15:0] RST_LAND_INTERVAL        = 16'd50;
    localparam logic [14:0] RST_LAND_DELTA_LIMIT     = 15'd80;
    localparam logic [7:0]  RST_LAND_STABLE_NEEDED   = 8'd4;

    typedef struct packed {
        logic [14:0] spin_speed_threshold;
        logic [14:0] spin_angle_limit;
        logic [15:0] spin_tick_limit;
        logic [14:0] tilt_limit;
        logic [14:0] land_angle_window;
        logic [15:0] land_interval;
        logic [14:0] land_delta_limit;
        logic [7:0]  land_stable_needed;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        spin_ticks;
        logic               spin_flag;
        logic [15:0]        land_ticks;
        logic [7:0]         still_samples;
        logic signed [15:0] last_sample_angle;
    } sup_state_t;

    typedef struct packed {
        logic spin_fault;
        logic tilt_fault;
        logic clear_position;
    } flags_t;

endpackage

### rtl/mfs_channels.sv
// ----------------------------------------------------------------------------
// mfs channels
// Valid/ready channels of the supervisor: sample in, result out, config.
// ----------------------------------------------------------------------------
interface mfs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] body_angle;
    logic               speed_cmd_zero;

    modport source (output valid, left_speed, right_speed, body_angle, speed_cmd_zero,
                    input ready);
    modport sink   (input valid, left_speed, right_speed, body_angle, speed_cmd_zero,
                    output ready);
endinterface

interface mfs_result_if;
    logic valid;
    logic ready;
    logic spin_fault;
    logic tilt_fault;
    logic clear_position;

    modport source (output valid, spin_fault, tilt_fault, clear_position, input ready);
    modport sink   (input valid, spin_fault, tilt_fault, clear_position, output ready);
endinterface

interface mfs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mfs_pkg::CfgIdxW-1:0]   index;
    logic [mfs_pkg::CfgDataW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfs_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module mfs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [mfs_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [mfs_pkg::CfgDataW-1:0]  wr_data,
    output mfs_pkg::cfg_t                 cfg
);

    mfs_pkg::cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spin_speed_threshold <= mfs_pkg::RST_SPIN_SPEED_THRESHOLD;
            cfg_reg.spin_angle_limit     <= mfs_pkg::RST_SPIN_ANGLE_LIMIT;
            cfg_reg.spin_tick_limit      <= mfs_pkg::RST_SPIN_TICK_LIMIT;
            cfg_reg.tilt_limit           <= mfs_pkg::RST_TILT_LIMIT;
            cfg_reg.land_angle_window    <= mfs_pkg::RST_LAND_ANGLE_WINDOW;
            cfg_reg.land_interval        <= mfs_pkg::RST_LAND_INTERVAL;
            cfg_reg.land_delta_limit     <= mfs_pkg::RST_LAND_DELTA_LIMIT;
            cfg_reg.land_stable_needed   <= mfs_pkg::RST_LAND_STABLE_NEEDED;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mfs_pkg::REG_SPIN_SPEED_THRESHOLD: cfg_reg.spin_speed_threshold <= wr_data[14:0];
                mfs_pkg::REG_SPIN_ANGLE_LIMIT:     cfg_reg.spin_angle_limit     <= wr_data[14:0];
                mfs_pkg::REG_SPIN_TICK_LIMIT:      cfg_reg.spin_tick_limit      <= wr_data;
                mfs_pkg::REG_TILT_LIMIT:           cfg_reg.tilt_limit           <= wr_data[14:0];
                mfs_pkg::REG_LAND_ANGLE_WINDOW:    cfg_reg.land_angle_window    <= wr_data[14:0];
                mfs_pkg::REG_LAND_INTERVAL:        cfg_reg.land_interval        <= wr_data;
                mfs_pkg::REG_LAND_DELTA_LIMIT:     cfg_reg.land_delta_limit     <= wr_data[14:0];
                mfs_pkg::REG_LAND_STABLE_NEEDED:   cfg_reg.land_stable_needed   <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mfs_step_logic.sv
// ----------------------------------------------------------------------------
// mfs_step_logic
// One control tick: spin detection, landing detection and tilt check.
// ----------------------------------------------------------------------------
module mfs_step_logic (
    input  mfs_pkg::cfg_t        cfg,
    input  mfs_pkg::sup_state_t  cur,
    input  logic signed [15:0]   left_speed,
    input  logic signed [15:0]   right_speed,
    input  logic signed [15:0]   body_angle,
    input  logic                 speed_cmd_zero,
    output mfs_pkg::sup_state_t  nxt,
    output mfs_pkg::flags_t      flags
);

    logic signed [17:0] left_s, right_s, angle_s, last_s, delta_s;
    logic signed [17:0] thr_s, alim_s, tlim_s, win_s, dlim_s;
    logic               upright, fwd, back, in_window, is_still;
    logic [15:0]        spin_inc, land_inc;
    logic [7:0]         still_inc;
    logic               spin_flag_mid;
    logic               clear;

    // Widen operands for signed compares
    assign left_s  = 18'(left_speed);
    assign right_s = 18'(right_speed);
    assign angle_s = 18'(body_angle);
    assign last_s  = 18'(cur.last_sample_angle);
    assign delta_s = angle_s - last_s;
    assign thr_s   = $signed({3'b000, cfg.spin_speed_threshold});
    assign alim_s  = $signed({3'b000, cfg.spin_angle_limit});
    assign tlim_s  = $signed({3'b000, cfg.tilt_limit});
    assign win_s   = $signed({3'b000, cfg.land_angle_window});
    assign dlim_s  = $signed({3'b000, cfg.land_delta_limit});

    assign upright   = (angle_s > -alim_s) && (angle_s < alim_s);
    assign fwd       = (left_s > thr_s) && (right_s > thr_s);
    assign back      = (left_s < -thr_s) && (right_s < -thr_s);
    assign in_window = (angle_s > -win_s) && (angle_s < win_s);
    assign is_still  = (delta_s < dlim_s) && (delta_s > -dlim_s);

    assign spin_inc  = cur.spin_ticks + 16'd1;
    assign land_inc  = cur.land_ticks + 16'd1;
    assign still_inc = cur.still_samples + 8'd1;

    // Advance spin counter, then landing sequence
    always_comb
    begin
        nxt           = cur;
        spin_flag_mid = cur.spin_flag;
        clear         = 1'b0;

        if (speed_cmd_zero && (fwd || back) && upright)
        begin
            if (spin_inc > cfg.spin_tick_limit)
            begin
                nxt.spin_ticks = '0;
                spin_flag_mid  = 1'b1;
            end
            else
            begin
                nxt.spin_ticks = spin_inc;
            end
        end
        else
        begin
            nxt.spin_ticks = '0;
        end
        nxt.spin_flag = spin_flag_mid;

        if (spin_flag_mid)
        begin
            if (in_window)
            begin
                if (land_inc >= cfg.land_interval)
                begin
                    nxt.land_ticks        = '0;
                    nxt.last_sample_angle = body_angle;
                    if (is_still)
                    begin
                        if (still_inc >= cfg.land_stable_needed)
                        begin
                            nxt.still_samples = '0;
                            nxt.spin_flag     = 1'b0;
                            clear             = 1'b1;
                        end
                        else
                        begin
                            nxt.still_samples = still_inc;
                        end
                    end
                    else
                    begin
                        nxt.still_samples = '0;
                    end
                end
                else
                begin
                    nxt.land_ticks = land_inc;
                end
            end
            else
            begin
                nxt.land_ticks    = '0;
                nxt.still_samples = '0;
            end
        end
    end

    assign flags.spin_fault     = nxt.spin_flag;
    assign flags.tilt_fault     = (angle_s > tlim_s) || (angle_s < -tlim_s);
    assign flags.clear_position = clear;

endmodule

### rtl/motor_fault_supervisor_unit.sv
// ----------------------------------------------------------------------------
// motor_fault_supervisor_unit
// Spin, landing and tilt supervisor for a two-wheeled balancing body.
// ----------------------------------------------------------------------------
// One sample word per control tick yields one result word. The block accepts
// a word every clock cycle unless the input register is full and the result
// register is stalled. A word accepted into the input register is written
// into the result register when it advances, with the single-pass tick logic
// and the state update between them; its result then stays valid until taken.
// The result register holds a word while the sink stalls, and the input
// register keeps taking a word as long as the result register can move.
// Configuration writes are taken in any cycle and must only be issued while
// no word is in flight.
// ----------------------------------------------------------------------------
module motor_fault_supervisor_unit (
    input  logic          clk,
    input  logic          rst_n,
    mfs_sample_if.sink    sample,
    mfs_result_if.source  result,
    mfs_cfg_if.sink       cfg
);

    mfs_pkg::cfg_t       cfg_regs;
    mfs_pkg::sup_state_t state_reg, state_next;
    mfs_pkg::flags_t     flags_next, flags_reg;

    logic               in_valid_reg;
    logic signed [15:0] left_reg, right_reg, angle_reg;
    logic               cmd_zero_reg;
    logic               out_valid_reg;
    logic               advance;

    assign cfg.ready = 1'b1;

    mfs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    mfs_step_logic u_step (
        .cfg            (cfg_regs),
        .cur            (state_reg),
        .left_speed     (left_reg),
        .right_speed    (right_reg),
        .body_angle     (angle_reg),
        .speed_cmd_zero (cmd_zero_reg),
        .nxt            (state_next),
        .flags          (flags_next)
    );

    // Move the input word on when the result register is free or drains
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            left_reg     <= sample.left_speed;
            right_reg    <= sample.right_speed;
            angle_reg    <= sample.body_angle;
            cmd_zero_reg <= sample.speed_cmd_zero;
        end
    end

    // Commit state and result when the word advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            flags_reg <= flags_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.spin_fault     = flags_reg.spin_fault;
    assign result.tilt_fault     = flags_reg.tilt_fault;
    assign result.clear_position = flags_reg.clear_position;

endmodule

### rtl/mfs_checker.sv
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks on the supervisor's result channel.
// ----------------------------------------------------------------------------
module mfs_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  logic res_ready,
    input  logic spin_fault,
    input  logic tilt_fault,
    input  logic clear_position
);

    // Hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(spin_fault) && $stable(tilt_fault)
                                    && $stable(clear_position))
        else $error("result payload changed while stalled");

    // Landing clears the spin fault in the same word
    a_clear_drops_spin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clear_position |-> !spin_fault)
        else $error("clear_position with spin_fault still set");

    // No result during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind motor_fault_supervisor_unit mfs_checker u_mfs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .spin_fault     (result.spin_fault),
    .tilt_fault     (result.tilt_fault),
    .clear_position (result.clear_position)
);
